/* rtl/lfu_pkg.sv */
// shared types and constants for the lfu cache replacement core
`default_nettype none
package lfu_pkg;
  localparam int unsigned KeyW   = 32;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CntW   = 32;
  localparam int unsigned LimW   = 5;
  localparam int unsigned InW    = 64;
  localparam int unsigned OutW   = 40;
  localparam logic        ReqGet = 1'b0;
  localparam logic        ReqPut = 1'b1;

  typedef enum logic [1:0] {
    CMD_NONE,
    CMD_BUMP,
    CMD_FILL,
    CMD_EVICT
  } cmd_e;

  typedef struct packed {
    logic load;
    logic search;
    cmd_e cmd;
  } ctrl_t;

  typedef struct packed {
    logic found;
    logic free_ok;
    logic any_valid;
    logic is_put;
    logic enabled;
  } stat_t;
endpackage
`default_nettype wire

/* rtl/lfu_datapath.sv */
// entry storage, key match, victim search and update logic
`default_nettype none
module lfu_datapath #(
  parameter int unsigned Entries = 16
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire lfu_pkg::ctrl_t             ctrl_i,
  output lfu_pkg::stat_t                  stat_o,
  input  wire logic [lfu_pkg::LimW-1:0]   limit_i,
  input  wire logic                       req_type_i,
  input  wire logic [lfu_pkg::KeyW-1:0]   key_i,
  input  wire logic [lfu_pkg::ValW-1:0]   val_i,
  output logic      [lfu_pkg::ValW-1:0]   rd_val_o
);
  import lfu_pkg::*;
  localparam int unsigned IdxW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned OccW = $clog2(Entries + 1);
  localparam int unsigned LimCmpW = (OccW > LimW + 1) ? OccW : LimW + 1;

  logic [Entries-1:0]     valid_q;
  logic [KeyW-1:0]        ekey_q  [Entries];
  logic [ValW-1:0]        eval_q  [Entries];
  logic [CntW-1:0]        ecnt_q  [Entries];
  logic [IdxW-1:0]        erank_q [Entries];
  logic [OccW-1:0]        occ_q;
  logic                   put_q;
  logic [KeyW-1:0]        key_q;
  logic [ValW-1:0]        val_q;
  logic                   en_q;
  logic                   found_q, free_ok_q;
  logic [IdxW-1:0]        hit_idx_q, free_idx_q, vic_idx_q;
  logic                   any_q;

  // effective limit
  logic [LimCmpW-1:0] lim_w;
  always_comb begin
    lim_w = LimCmpW'(limit_i);
    if (lim_w > LimCmpW'(Entries)) lim_w = LimCmpW'(Entries);
  end

  // match and free slot selection (registered)
  logic           found_w, free_w, any_w;
  logic [IdxW-1:0] hit_w, free_idx_w, vic_w;
  always_comb begin
    found_w = 1'b0; free_w = 1'b0;
    hit_w = '0; free_idx_w = '0;
    for (int i = Entries - 1; i >= 0; i--) begin
      if (valid_q[i] && ekey_q[i] == key_q) begin
        found_w = 1'b1; hit_w = IdxW'(i);
      end
      if (!valid_q[i]) begin
        free_w = 1'b1; free_idx_w = IdxW'(i);
      end
    end
  end

  // victim selection as a compare tree: lowest count, then oldest
  logic [IdxW-1:0] win_idx  [Entries];
  logic [CntW-1:0] win_cnt  [Entries];
  logic [IdxW-1:0] win_rank [Entries];
  logic            win_ok   [Entries];
  always_comb begin
    for (int i = 0; i < int'(Entries); i++) begin
      win_idx[i]  = IdxW'(i);
      win_cnt[i]  = ecnt_q[i];
      win_rank[i] = erank_q[i];
      win_ok[i]   = valid_q[i];
    end
    for (int s = 1; s < int'(Entries); s = s * 2) begin
      for (int i = 0; i + s < int'(Entries); i = i + 2 * s) begin
        if (win_ok[i+s] && (!win_ok[i] || win_cnt[i+s] < win_cnt[i] ||
            (win_cnt[i+s] == win_cnt[i] && win_rank[i+s] > win_rank[i]))) begin
          win_idx[i]  = win_idx[i+s];
          win_cnt[i]  = win_cnt[i+s];
          win_rank[i] = win_rank[i+s];
          win_ok[i]   = 1'b1;
        end
      end
    end
    vic_w = win_idx[0];
    any_w = win_ok[0];
  end

  logic [IdxW-1:0] tgt;
  logic [IdxW:0]   old_rank;
  always_comb begin
    tgt = hit_idx_q;
    case (ctrl_i.cmd)
      CMD_FILL:  tgt = free_idx_q;
      CMD_EVICT: tgt = vic_idx_q;
      default:   tgt = hit_idx_q;
    endcase
    old_rank = (ctrl_i.cmd == CMD_FILL) ? {1'b1, {IdxW{1'b0}}} : {1'b0, erank_q[tgt]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      occ_q   <= '0;
    end else if (ctrl_i.cmd != CMD_NONE) begin
      valid_q[tgt] <= 1'b1;
      if (ctrl_i.cmd == CMD_FILL) occ_q <= occ_q + OccW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      put_q <= req_type_i;
      key_q <= key_i;
      val_q <= val_i;
      en_q  <= (lim_w != '0);
    end
    if (ctrl_i.search) begin
      found_q    <= found_w;
      hit_idx_q  <= hit_w;
      free_idx_q <= free_idx_w;
      free_ok_q  <= free_w && (LimCmpW'(occ_q) < lim_w);
      vic_idx_q  <= vic_w;
      any_q      <= any_w;
      rd_val_o   <= (en_q && found_w && !put_q) ? eval_q[hit_w] : '0;
    end
    if (ctrl_i.cmd != CMD_NONE) begin
      for (int i = 0; i < Entries; i++) begin
        if (IdxW'(i) != tgt && valid_q[i] && {1'b0, erank_q[i]} < old_rank)
          erank_q[i] <= erank_q[i] + IdxW'(1);
      end
      erank_q[tgt] <= '0;
      if (ctrl_i.cmd == CMD_BUMP) begin
        if (ecnt_q[tgt] != '1) ecnt_q[tgt] <= ecnt_q[tgt] + CntW'(1);
        if (put_q) eval_q[tgt] <= val_q;
      end else begin
        ekey_q[tgt] <= key_q;
        eval_q[tgt] <= val_q;
        ecnt_q[tgt] <= CntW'(1);
      end
    end
  end

  assign stat_o = '{found: found_q, free_ok: free_ok_q, any_valid: any_q,
                    is_put: put_q, enabled: en_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_FILL |-> !valid_q[free_idx_q])
    else $error("fill into occupied slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.cmd == CMD_EVICT |-> valid_q[vic_idx_q])
    else $error("evict of empty slot");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(occ_q))
    else $error("occupancy mismatch");
endmodule
`default_nettype wire

/* rtl/lfu_ctrl.sv */
// request sequencing state machine
`default_nettype none
module lfu_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output lfu_pkg::ctrl_t      ctrl_o,
  input  wire lfu_pkg::stat_t stat_i,
  output logic                hit_o,
  output logic                evicted_o
);
  import lfu_pkg::*;
  typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_UPDATE, S_OUT} state_e;
  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);
  always_comb begin
    ctrl_o.load   = in_valid_i && in_ready_o;
    ctrl_o.search = (state_q == S_SEARCH);
    ctrl_o.cmd    = CMD_NONE;
    if (state_q == S_UPDATE && stat_i.enabled) begin
      if (stat_i.found) ctrl_o.cmd = CMD_BUMP;
      else if (stat_i.is_put) begin
        if (stat_i.free_ok || !stat_i.any_valid) ctrl_o.cmd = CMD_FILL;
        else ctrl_o.cmd = CMD_EVICT;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
      hit_o       <= 1'b0;
      evicted_o   <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE:   if (in_valid_i) state_q <= S_SEARCH;
        S_SEARCH: state_q <= S_UPDATE;
        S_UPDATE: begin
          hit_o       <= stat_i.enabled && stat_i.found;
          evicted_o   <= (ctrl_o.cmd == CMD_EVICT);
          out_valid_o <= 1'b1;
          state_q     <= S_OUT;
        end
        S_OUT: if (out_ready_i) begin
          out_valid_o <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o) else $error("accept while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    evicted_o && out_valid_o |-> !hit_o) else $error("hit with eviction");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_o.cmd != CMD_NONE |=> out_valid_o) else $error("update without result");
endmodule
`default_nettype wire

/* rtl/lfu_cache_replacement_core.sv */
// top level of the lfu cache with lru tie break
// an accepted transaction passes the search and update states over the entry
// registers before its result is valid; a new transaction is accepted only
// after the previous result has been taken
// reset: all entries invalid, occupancy zero, capacity limit 16
`default_nettype none
module lfu_cache_replacement_core #(
  parameter int unsigned Entries = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [4:0]                cfg_wdata_i,
  input  wire logic                      s_axis_tvalid,
  output logic                           s_axis_tready,
  input  wire logic                      s_axis_tuser,   // req_type
  input  wire logic [lfu_pkg::InW-1:0]   s_axis_tdata,   // lookup_key, write_value
  output logic                           m_axis_tvalid,
  input  wire logic                      m_axis_tready,
  output logic      [lfu_pkg::OutW-1:0]  m_axis_tdata    // hit, read_value, evicted, pad
);
  import lfu_pkg::*;
  ctrl_t ctrl;
  stat_t stat;
  logic [LimW-1:0] limit_q;
  logic [ValW-1:0] rd_val;
  logic hit, ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= LimW'(16);
    else if (cfg_we_i) limit_q <= cfg_wdata_i;
  end

  lfu_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .ctrl_o(ctrl), .stat_i(stat), .hit_o(hit), .evicted_o(ev)
  );

  lfu_datapath #(.Entries(Entries)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat), .limit_i(limit_q),
    .req_type_i(s_axis_tuser), .key_i(s_axis_tdata[31:0]),
    .val_i(s_axis_tdata[63:32]), .rd_val_o(rd_val)
  );

  assign m_axis_tdata = {6'b0, ev, rd_val, hit};
endmodule
`default_nettype wire

/* bench/tb_lfu_cache_replacement_core.sv */
// testbench for the lfu cache replacement core with an internal predictor
`default_nettype none
module tb_lfu_cache_replacement_core;
  import lfu_pkg::*;

  localparam int NumSlots = 16;
  localparam int IdleLimit = 4000;

  typedef struct packed {
    logic        req;
    logic [31:0] key;
    logic [31:0] val;
  } req_item_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] rdata;
    logic        evicted;
  } reply_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [4:0]  cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic        s_axis_tuser = 1'b0;
  logic [63:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;

  lfu_cache_replacement_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tuser, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // shadow copy of the store
  logic        sh_valid [NumSlots];
  logic [31:0] sh_key   [NumSlots];
  logic [31:0] sh_val   [NumSlots];
  logic [31:0] sh_cnt   [NumSlots];
  logic [31:0] sh_rank  [NumSlots];
  int unsigned sh_occ;
  logic [4:0]  sh_limit;

  req_item_t   pending_q[$];
  reply_t      reply_q[$];
  logic [31:0] key_pool[24];
  int          send_gap, recv_gap, idle_cycles, errors;
  bit          hold_send;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic void make_recent(int s, logic [31:0] old_rank);
    for (int i = 0; i < NumSlots; i++)
      if (i != s && sh_valid[i] && sh_rank[i] < old_rank) sh_rank[i]++;
    sh_rank[s] = '0;
  endfunction

  function automatic reply_t lfu_lookup(req_item_t it);
    reply_t      rsp;
    int unsigned lim;
    int          found, slot;
    logic [31:0] old_rank;
    rsp = '0;
    found = -1;
    slot = -1;
    lim = (sh_limit > NumSlots) ? NumSlots : sh_limit;
    if (lim == 0) return rsp;
    for (int i = 0; i < NumSlots; i++)
      if (found < 0 && sh_valid[i] && sh_key[i] == it.key) found = i;
    if (found >= 0) begin
      rsp.hit = 1'b1;
      if (it.req == ReqPut) sh_val[found] = it.val;
      else rsp.rdata = sh_val[found];
      if (sh_cnt[found] != 32'hFFFF_FFFF) sh_cnt[found]++;
      make_recent(found, sh_rank[found]);
    end else if (it.req == ReqPut) begin
      if (sh_occ < lim)
        for (int i = 0; i < NumSlots; i++)
          if (slot < 0 && !sh_valid[i]) slot = i;
      if (slot >= 0) begin
        old_rank = 32'hFFFF_FFFF;
        sh_occ++;
      end else begin
        for (int i = 0; i < NumSlots; i++)
          if (sh_valid[i] && (slot < 0 || sh_cnt[i] < sh_cnt[slot] ||
              (sh_cnt[i] == sh_cnt[slot] && sh_rank[i] > sh_rank[slot])))
            slot = i;
        old_rank = sh_rank[slot];
        rsp.evicted = 1'b1;
      end
      sh_valid[slot] = 1'b1;
      sh_key[slot] = it.key;
      sh_val[slot] = it.val;
      sh_cnt[slot] = 32'd1;
      make_recent(slot, old_rank);
    end
    return rsp;
  endfunction

  // sender
  always @(negedge clk_i) begin
    if (!rst_ni || send_gap > 0 || hold_send || pending_q.size() == 0) begin
      s_axis_tvalid <= 1'b0;
      if (send_gap > 0) send_gap--;
    end else begin
      s_axis_tvalid <= 1'b1;
      s_axis_tuser <= pending_q[0].req;
      s_axis_tdata <= {pending_q[0].val, pending_q[0].key};
    end
  end

  // receiver
  always @(negedge clk_i) begin
    if (recv_gap > 0) begin
      recv_gap--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap = pick_gap();
    end
  end

  // transaction capture, checking and watchdog
  always @(posedge clk_i) begin
    reply_t got, want;
    idle_cycles++;
    if (s_axis_tvalid && s_axis_tready) begin
      idle_cycles = 0;
      reply_q.push_back(lfu_lookup(pending_q.pop_front()));
      send_gap = pick_gap();
    end
    if (m_axis_tvalid && m_axis_tready) begin
      idle_cycles = 0;
      got = {m_axis_tdata[0], m_axis_tdata[32:1], m_axis_tdata[33]};
      if (reply_q.size() == 0) begin
        $error("unexpected result transaction");
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (got.hit !== want.hit) begin
          $error("hit expected %0h actual %0h", want.hit, got.hit);
          errors++;
        end
        if (got.rdata !== want.rdata) begin
          $error("read_value expected %0h actual %0h", want.rdata, got.rdata);
          errors++;
        end
        if (got.evicted !== want.evicted) begin
          $error("evicted expected %0h actual %0h", want.evicted, got.evicted);
          errors++;
        end
      end
    end
    if (idle_cycles >= IdleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_req(logic req, logic [31:0] key, logic [31:0] val);
    req_item_t it;
    it.req = req;
    it.key = key;
    it.val = val;
    pending_q.push_back(it);
  endtask

  task automatic push_random(int n);
    logic [31:0] key;
    for (int k = 0; k < n; k++) begin
      key = ($urandom_range(0, 9) == 0) ? $urandom() : key_pool[$urandom_range(0, 23)];
      push_req($urandom_range(0, 1), key, $urandom());
    end
  endtask

  task automatic drain();
    hold_send = 1'b0;
    wait (pending_q.size() == 0 && reply_q.size() == 0);
    hold_send = 1'b1;
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_limit(logic [4:0] lim);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= lim;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sh_limit = lim;
    idle_cycles = 0;
  endtask

  initial begin
    errors = 0;
    send_gap = 0;
    recv_gap = 0;
    idle_cycles = 0;
    hold_send = 1'b1;
    sh_occ = 0;
    sh_limit = 5'd16;
    for (int i = 0; i < NumSlots; i++) begin
      sh_valid[i] = 1'b0;
      sh_key[i] = '0;
      sh_val[i] = '0;
      sh_cnt[i] = '0;
      sh_rank[i] = '0;
    end
    key_pool[0] = 32'h7FFF_FFFF;
    key_pool[1] = 32'h8000_0000;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    for (int i = 4; i < 24; i++) key_pool[i] = $urandom();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // extremes, hits, misses, put update
    push_req(ReqGet, 32'h7FFF_FFFF, 32'h1234_5678);
    push_req(ReqPut, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(ReqPut, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(ReqGet, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
    push_req(ReqGet, 32'h8000_0000, 32'h0);
    push_req(ReqPut, 32'h8000_0000, 32'hFFFF_FFFF);
    push_req(ReqGet, 32'h8000_0000, 32'h0);
    // fill past capacity, forcing evictions with equal counts
    for (int i = 0; i < 17; i++) push_req(ReqPut, 32'h100 + i, 32'hA000 + i);
    drain();

    set_limit(5'd0);
    push_req(ReqGet, 32'h100, 32'h0);
    push_req(ReqPut, 32'h555, 32'h1);
    push_random(20);
    drain();

    set_limit(5'd2);
    push_random(120);
    drain();

    set_limit(5'd31);
    push_random(140);
    drain();

    set_limit(5'd1);
    push_random(80);
    drain();

    set_limit(5'd5);
    push_random(140);
    drain();

    set_limit(5'd16);
    push_random(150);
    drain();

    if (errors == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end
endmodule
`default_nettype wire
